@@ hw/rtl/tps_pkg.sv @@
// Shared types, constants and helper functions for the turnout pair supervisor.
package tps_pkg;

    localparam int TIMER_BITS = 16;
    localparam int CFG_BITS   = 16;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [TIMER_BITS-1:0] CNT_MAX = '1;

    localparam logic [1:0] DIR_A       = 2'd0;
    localparam logic [1:0] DIR_B       = 2'd1;
    localparam logic [1:0] DIR_INVALID = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] REG_FB_INV    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DRV_INV   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PERIOD    = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_ATT_LIMIT = 2'd3;

    localparam logic [CFG_BITS-1:0] PERIOD_RESET = 16'd1000;
    localparam logic [CFG_BITS-1:0] LIMIT_RESET  = 16'd10;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_WAIT_X = 3'b010,
        PH_WAIT_Y = 3'b100
    } phase_t;

    // Values after the update for one word, as seen by the result stage.
    typedef struct packed {
        logic [1:0] drive_bits;
        logic       busy;
        logic       done;
        logic [1:0] last_fail;
        logic [1:0] x_target;
        logic [1:0] y_target;
    } seq_out_t;

    // A zero setting behaves as one; a setting above the counter range is clipped.
    function automatic logic [TIMER_BITS-1:0] clip_count(input logic [CFG_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        if (w == 32'd0)
        begin
            w = 32'd1;
        end
        if (w > 32'(CNT_MAX))
        begin
            w = 32'(CNT_MAX);
        end
        return w[TIMER_BITS-1:0];
    endfunction

    function automatic logic [1:0] decode_pair(input logic a, input logic b);
        logic [1:0] d;
        if (a && !b)
        begin
            d = DIR_A;
        end
        else if (!a && b)
        begin
            d = DIR_B;
        end
        else
        begin
            d = DIR_INVALID;
        end
        return d;
    endfunction

endpackage

@@ hw/rtl/tps_fb_decode.sv @@
// Feedback pin inversion and decoding into one direction per point.
module tps_fb_decode
    import tps_pkg::*;
(
    input  logic [3:0] pins,
    input  logic [3:0] invert_mask,
    output logic [1:0] x_seen,
    output logic [1:0] y_seen
);

    logic [3:0] pins_adj;

    assign pins_adj = pins ^ invert_mask;
    assign x_seen   = decode_pair(pins_adj[0], pins_adj[1]);
    assign y_seen   = decode_pair(pins_adj[2], pins_adj[3]);

endmodule

@@ hw/rtl/tps_sequencer.sv @@
// Set command sequencer: targets, drive levels, period and attempt counters.
module tps_sequencer
    import tps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic                  op,
    input  logic [1:0]            target_dir,
    input  logic [1:0]            x_seen,
    input  logic [1:0]            y_seen,
    input  logic [1:0]            drive_inv,
    input  logic [CFG_BITS-1:0]   period_cfg,
    input  logic [CFG_BITS-1:0]   limit_cfg,
    output seq_out_t              seq
);

    phase_t                phase_reg, phase_next;
    logic [1:0]            x_target_reg, x_target_next;
    logic [1:0]            y_target_reg, y_target_next;
    logic [TIMER_BITS-1:0] tick_reg, tick_next;
    logic [TIMER_BITS-1:0] attempt_reg, attempt_next;
    logic                  x_failed_reg, x_failed_next;
    logic [1:0]            last_fail_reg, last_fail_next;
    logic [1:0]            drive_reg, drive_next;

    logic [1:0]            tdir;
    logic [TIMER_BITS-1:0] tick_inc;
    logic [TIMER_BITS-1:0] attempt_inc;
    logic                  elapsed;
    logic                  limit_hit;
    logic                  x_hit;
    logic                  y_hit;
    logic                  done;

    assign tdir = (target_dir == 2'd3) ? DIR_INVALID : target_dir;

    // One tick of the current wait period, with the counters held at full scale.
    assign tick_inc    = (tick_reg < CNT_MAX) ? tick_reg + 1'b1 : tick_reg;
    assign elapsed     = tick_inc >= clip_count(period_cfg);
    assign attempt_inc = (attempt_reg < CNT_MAX) ? attempt_reg + 1'b1 : attempt_reg;
    assign limit_hit   = attempt_inc >= clip_count(limit_cfg);
    assign x_hit       = x_seen == x_target_reg;
    assign y_hit       = y_seen == y_target_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        x_target_next  = x_target_reg;
        y_target_next  = y_target_reg;
        tick_next      = tick_reg;
        attempt_next   = attempt_reg;
        x_failed_next  = x_failed_reg;
        last_fail_next = last_fail_reg;
        drive_next     = drive_reg;
        done           = 1'b0;
        if (op)
        begin
            x_target_next = tdir;
            drive_next    = {drive_reg[1], (tdir == DIR_B) ^ drive_inv[0]};
            tick_next     = '0;
            attempt_next  = '0;
            x_failed_next = 1'b0;
            phase_next    = PH_WAIT_X;
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                end
                PH_WAIT_X:
                begin
                    tick_next = tick_inc;
                    if (elapsed)
                    begin
                        tick_next    = '0;
                        attempt_next = attempt_inc;
                        if (x_hit || limit_hit)
                        begin
                            x_failed_next = !x_hit;
                            y_target_next = x_target_reg;
                            drive_next    = {(x_target_reg == DIR_B) ^ drive_inv[1],
                                             drive_reg[0]};
                            attempt_next  = '0;
                            phase_next    = PH_WAIT_Y;
                        end
                    end
                end
                PH_WAIT_Y:
                begin
                    tick_next = tick_inc;
                    if (elapsed)
                    begin
                        tick_next    = '0;
                        attempt_next = attempt_inc;
                        if (y_hit || limit_hit)
                        begin
                            last_fail_next = {x_failed_reg, !y_hit};
                            attempt_next   = '0;
                            phase_next     = PH_IDLE;
                            done           = 1'b1;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            x_target_reg  <= DIR_A;
            y_target_reg  <= DIR_A;
            tick_reg      <= '0;
            attempt_reg   <= '0;
            x_failed_reg  <= 1'b0;
            last_fail_reg <= 2'd0;
            drive_reg     <= 2'd0;
        end
        else if (fire)
        begin
            phase_reg     <= phase_next;
            x_target_reg  <= x_target_next;
            y_target_reg  <= y_target_next;
            tick_reg      <= tick_next;
            attempt_reg   <= attempt_next;
            x_failed_reg  <= x_failed_next;
            last_fail_reg <= last_fail_next;
            drive_reg     <= drive_next;
        end
    end

    assign seq.drive_bits = drive_next;
    assign seq.busy       = phase_next != PH_IDLE;
    assign seq.done       = done;
    assign seq.last_fail  = last_fail_next;
    assign seq.x_target   = x_target_next;
    assign seq.y_target   = y_target_next;

endmodule

@@ hw/rtl/tps_status.sv @@
// Agreement, common direction and train state suitability of the points.
module tps_status
    import tps_pkg::*;
(
    input  logic [1:0] x_seen,
    input  logic [1:0] y_seen,
    input  logic [1:0] x_target,
    input  logic [1:0] y_target,
    input  logic [2:0] train_state,
    output logic [1:0] current_dir,
    output logic       points_agree,
    output logic       set_correctly
);

    always_comb
    begin
        points_agree = (x_seen == x_target) && (y_seen == y_target) && (x_seen == y_seen);
        current_dir  = points_agree ? x_seen : DIR_INVALID;
        case (train_state)
            3'd0, 3'd1, 3'd2: set_correctly = current_dir == DIR_A;
            3'd3, 3'd4, 3'd5: set_correctly = current_dir == DIR_B;
            3'd6:             set_correctly = points_agree;
            default:          set_correctly = 1'b0;
        endcase
    end

endmodule

@@ hw/rtl/turnout_pair_supervisor_core.sv @@
// Top level of the turnout pair supervisor: handshake stages, registers and result word.
//
// Usage:
// Each input word carries an operation (time tick or set command), a target
// direction, the four raw feedback pins and the train state. Every input word
// yields exactly one result word with the drive levels, busy and done flags,
// the failure code of the last finished command and the decoded point status.
// Both channels use valid and stall; a word moves at a clock edge where valid
// is high and stall is low.
// The word is held in an input register; once the result register is free, an edge
// updates the sequencer state and loads the result register. Throughput
// is one word per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its word and the input
// register fills; in_stall is raised only when both are occupied.
// Reset clears both stages, all sequencer state, and returns the configuration
// registers to their defaults (period 1000 ticks, attempt limit 10, no
// inversion). Configuration writes are taken whenever cfg_we is high and
// should only be issued while no word is in flight.
module turnout_pair_supervisor_core
    import tps_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    op,
    input  logic [1:0]              target_dir,
    input  logic [3:0]              feedback_pins,
    input  logic [2:0]              train_state,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    x_drive,
    output logic                    y_drive,
    output logic                    busy_res,
    output logic                    done_res,
    output logic [1:0]              fail_code,
    output logic [1:0]              x_seen,
    output logic [1:0]              y_seen,
    output logic [1:0]              current_dir,
    output logic                    points_agree,
    output logic                    set_correctly
);

    // Configuration registers.
    logic [3:0]          fb_inv_reg;
    logic [1:0]          drv_inv_reg;
    logic [CFG_BITS-1:0] period_reg;
    logic [CFG_BITS-1:0] limit_reg;

    // Input stage.
    logic       s1_valid_reg, s1_valid_next;
    logic       s1_op_reg;
    logic [1:0] s1_tdir_reg;
    logic [3:0] s1_pins_reg;
    logic [2:0] s1_ts_reg;

    // Result stage.
    logic       out_valid_reg, out_valid_next;
    logic       x_drive_reg, y_drive_reg, busy_reg, done_reg;
    logic [1:0] fail_reg, x_seen_reg, y_seen_reg, cur_dir_reg;
    logic       agree_reg, set_ok_reg;

    logic       in_accept;
    logic       out_free;
    logic       fire;
    logic [1:0] xs, ys;
    logic [1:0] cur_dir;
    logic       agree;
    logic       set_ok;
    seq_out_t   seq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_inv_reg  <= 4'd0;
            drv_inv_reg <= 2'd0;
            period_reg  <= PERIOD_RESET;
            limit_reg   <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FB_INV:    fb_inv_reg  <= cfg_data[3:0];
                REG_DRV_INV:   drv_inv_reg <= cfg_data[1:0];
                REG_PERIOD:    period_reg  <= cfg_data;
                REG_ATT_LIMIT: limit_reg   <= cfg_data;
                default:       period_reg  <= period_reg;
            endcase
        end
    end

    // The result register frees up when empty or when its word is taken this
    // cycle, so the input stage can hand over a word in every cycle that it is free.
    assign out_free  = !out_valid_reg || !out_stall;
    assign fire      = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (fire)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg   <= op;
            s1_tdir_reg <= target_dir;
            s1_pins_reg <= feedback_pins;
            s1_ts_reg   <= train_state;
        end
    end

    tps_fb_decode u_decode (
        .pins        (s1_pins_reg),
        .invert_mask (fb_inv_reg),
        .x_seen      (xs),
        .y_seen      (ys)
    );

    tps_sequencer u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .op         (s1_op_reg),
        .target_dir (s1_tdir_reg),
        .x_seen     (xs),
        .y_seen     (ys),
        .drive_inv  (drv_inv_reg),
        .period_cfg (period_reg),
        .limit_cfg  (limit_reg),
        .seq        (seq)
    );

    // Status uses the targets as they stand after this word's update.
    tps_status u_status (
        .x_seen        (xs),
        .y_seen        (ys),
        .x_target      (seq.x_target),
        .y_target      (seq.y_target),
        .train_state   (s1_ts_reg),
        .current_dir   (cur_dir),
        .points_agree  (agree),
        .set_correctly (set_ok)
    );

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            x_drive_reg <= seq.drive_bits[0];
            y_drive_reg <= seq.drive_bits[1];
            busy_reg    <= seq.busy;
            done_reg    <= seq.done;
            fail_reg    <= seq.last_fail;
            x_seen_reg  <= xs;
            y_seen_reg  <= ys;
            cur_dir_reg <= cur_dir;
            agree_reg   <= agree;
            set_ok_reg  <= set_ok;
        end
    end

    assign out_valid     = out_valid_reg;
    assign x_drive       = x_drive_reg;
    assign y_drive       = y_drive_reg;
    assign busy_res      = busy_reg;
    assign done_res      = done_reg;
    assign fail_code     = fail_reg;
    assign x_seen        = x_seen_reg;
    assign y_seen        = y_seen_reg;
    assign current_dir   = cur_dir_reg;
    assign points_agree  = agree_reg;
    assign set_correctly = set_ok_reg;

    // A finished command leaves the sequencer idle, so done and busy never meet.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(done_reg && busy_reg))
        else $error("done and busy reported together");

    // A held input word with an empty result register must move on at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("input word not handed to the result register");

    // The input side is only held off when both stages are occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with a free stage");

    // A reported common direction implies agreement of the two points.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (cur_dir_reg != DIR_INVALID) |-> agree_reg)
        else $error("common direction without agreement");

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the turnout pair supervisor core.
`timescale 1ns / 1ps

module tb
    import tps_pkg::*;
();

    // Operation and train state codes carried by an input word.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    localparam logic [2:0] TS_A_ARRIVE = 3'd2;
    localparam logic [2:0] TS_B_ARRIVE = 3'd5;
    localparam logic [2:0] TS_BOTH_IN  = 3'd6;

    // Cycles from acceptance of a word to its result, with some margin.
    localparam int LATENCY_SLACK = 4;
    localparam int PHASE_WORDS   = 200;
    localparam int HOLD_CYCLES   = 300;

    // One result word, field for field as on the output ports.
    typedef struct packed {
        logic       x_drive;
        logic       y_drive;
        logic       busy;
        logic       done;
        logic [1:0] fail;
        logic [1:0] xs;
        logic [1:0] ys;
        logic [1:0] cur;
        logic       agree;
        logic       ok;
    } status_t;

    typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

    // One row of the directed stimulus: either an input word or a register write.
    typedef struct {
        row_kind_t                 kind;
        logic                      o;
        logic [1:0]                t;
        logic [3:0]                p;
        logic [2:0]                s;
        bit                        fixed_on;
        status_t                   fixed;
        logic [CFG_IDX_BITS-1:0]   idx;
        logic [CFG_BITS-1:0]       val;
    } plan_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0]     cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic                    op;
    logic [1:0]              target_dir;
    logic [3:0]              feedback_pins;
    logic [2:0]              train_state;
    logic                    out_valid;
    logic                    out_stall;
    logic                    x_drive;
    logic                    y_drive;
    logic                    busy_res;
    logic                    done_res;
    logic [1:0]              fail_code;
    logic [1:0]              x_seen;
    logic [1:0]              y_seen;
    logic [1:0]              current_dir;
    logic                    points_agree;
    logic                    set_correctly;

    turnout_pair_supervisor_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .target_dir    (target_dir),
        .feedback_pins (feedback_pins),
        .train_state   (train_state),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .x_drive       (x_drive),
        .y_drive       (y_drive),
        .busy_res      (busy_res),
        .done_res      (done_res),
        .fail_code     (fail_code),
        .x_seen        (x_seen),
        .y_seen        (y_seen),
        .current_dir   (current_dir),
        .points_agree  (points_agree),
        .set_correctly (set_correctly)
    );

    // Our own copy of the configuration registers, kept in step with every write.
    logic [3:0]          fb_inv;
    logic [1:0]          drv_inv;
    logic [CFG_BITS-1:0] period_cfg;
    logic [CFG_BITS-1:0] limit_cfg;

    // Our own copy of the sequencer state.
    logic [1:0]            sv_x_target;
    logic [1:0]            sv_y_target;
    phase_t                sv_phase;
    logic [TIMER_BITS-1:0] sv_ticks;
    logic [TIMER_BITS-1:0] sv_attempts;
    logic                  sv_x_failed;
    logic [1:0]            sv_last_fail;
    logic [1:0]            sv_drive;

    status_t   pending_status_q[$];
    plan_row_t plan_q[$];
    int        mismatch_count;

    // Idle rates in percent for each side, and a request for a long receiver hold-off.
    int send_idle_pct;
    int recv_idle_pct;
    int hold_request;

    always #5 clk = ~clk;

    // A zero setting counts as one. The counters are as wide as the registers, so a
    // setting can never exceed the largest count and no further clipping is needed.
    function automatic logic [TIMER_BITS-1:0] eff_count(input logic [CFG_BITS-1:0] v);
        return (v == '0) ? TIMER_BITS'(1) : TIMER_BITS'(v);
    endfunction

    // The A pin alone means direction A, the B pin alone means B, anything else is invalid.
    function automatic logic [1:0] pair_dir(input logic a_pin, input logic b_pin);
        logic [1:0] d;
        case ({a_pin, b_pin})
            2'b10:   d = DIR_A;
            2'b01:   d = DIR_B;
            default: d = DIR_INVALID;
        endcase
        return d;
    endfunction

    // Counts one tick of the running period. Returns 1 when the period has just ended,
    // in which case the attempt counter has moved on by one.
    function automatic logic period_ends();
        if (sv_ticks != CNT_MAX)
        begin
            sv_ticks = sv_ticks + 1'b1;
        end
        if (sv_ticks >= eff_count(period_cfg))
        begin
            sv_ticks = '0;
            if (sv_attempts != CNT_MAX)
            begin
                sv_attempts = sv_attempts + 1'b1;
            end
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advances our copy of the supervisor by one accepted word and returns the status
    // word the block must report for it.
    function automatic status_t supervise_word(input logic o, input logic [1:0] t,
                                               input logic [3:0] p, input logic [2:0] s);
        logic [3:0] pins;
        logic [1:0] dir;
        logic       hit;
        status_t    r;
        pins = p ^ fb_inv;
        dir = (t > DIR_INVALID) ? DIR_INVALID : t;
        r = '0;
        r.xs = pair_dir(pins[0], pins[1]);
        r.ys = pair_dir(pins[2], pins[3]);
        if (o == OP_SET)
        begin
            // A new command always wins, even over one still in progress.
            sv_x_target = dir;
            sv_drive[0] = (dir == DIR_B) ^ drv_inv[0];
            sv_ticks = '0;
            sv_attempts = '0;
            sv_x_failed = 1'b0;
            sv_phase = PH_WAIT_X;
        end
        else if (sv_phase == PH_WAIT_X)
        begin
            if (period_ends())
            begin
                hit = (r.xs == sv_x_target);
                if (hit || sv_attempts >= eff_count(limit_cfg))
                begin
                    sv_x_failed = !hit;
                    sv_y_target = sv_x_target;
                    sv_drive[1] = (sv_y_target == DIR_B) ^ drv_inv[1];
                    sv_ticks = '0;
                    sv_attempts = '0;
                    sv_phase = PH_WAIT_Y;
                end
            end
        end
        else if (sv_phase == PH_WAIT_Y)
        begin
            if (period_ends())
            begin
                hit = (r.ys == sv_y_target);
                if (hit || sv_attempts >= eff_count(limit_cfg))
                begin
                    sv_last_fail = {sv_x_failed, !hit};
                    sv_ticks = '0;
                    sv_attempts = '0;
                    sv_phase = PH_IDLE;
                    r.done = 1'b1;
                end
            end
        end
        r.x_drive = sv_drive[0];
        r.y_drive = sv_drive[1];
        r.busy = (sv_phase != PH_IDLE);
        r.fail = sv_last_fail;
        r.agree = (r.xs == sv_x_target) && (r.ys == sv_y_target) && (r.xs == r.ys);
        r.cur = r.agree ? r.xs : DIR_INVALID;
        if (s <= TS_A_ARRIVE)
        begin
            r.ok = (r.cur == DIR_A);
        end
        else if (s <= TS_B_ARRIVE)
        begin
            r.ok = (r.cur == DIR_B);
        end
        else if (s == TS_BOTH_IN)
        begin
            r.ok = r.agree;
        end
        else
        begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

    // Builds feedback pins that report the current targets, so that commands mostly
    // complete. An invalid target is met by both pins high or both low.
    function automatic logic [3:0] matching_pins();
        logic [3:0] p;
        case (sv_x_target)
            DIR_A:   p[1:0] = 2'b01;
            DIR_B:   p[1:0] = 2'b10;
            default: p[1:0] = {2{1'($urandom_range(0, 1))}};
        endcase
        case (sv_y_target)
            DIR_A:   p[3:2] = 2'b01;
            DIR_B:   p[3:2] = 2'b10;
            default: p[3:2] = {2{1'($urandom_range(0, 1))}};
        endcase
        return p ^ fb_inv;
    endfunction

    function automatic void row_word(input logic o, input logic [1:0] t,
                                     input logic [3:0] p, input logic [2:0] s);
        plan_row_t row;
        row = '{kind: ROW_WORD, o: o, t: t, p: p, s: s, fixed_on: 1'b0, fixed: '0,
                idx: '0, val: '0};
        plan_q.push_back(row);
    endfunction

    function automatic void row_fixed(input logic o, input logic [1:0] t,
                                      input logic [3:0] p, input logic [2:0] s,
                                      input status_t want);
        plan_row_t row;
        row = '{kind: ROW_WORD, o: o, t: t, p: p, s: s, fixed_on: 1'b1, fixed: want,
                idx: '0, val: '0};
        plan_q.push_back(row);
    endfunction

    function automatic void row_cfg(input logic [CFG_IDX_BITS-1:0] idx,
                                    input logic [CFG_BITS-1:0] val);
        plan_row_t row;
        row = '{kind: ROW_CFG, o: OP_TICK, t: '0, p: '0, s: '0, fixed_on: 1'b0,
                fixed: '0, idx: idx, val: val};
        plan_q.push_back(row);
    endfunction

    // Offers one word and waits until it is taken. The predictor runs at acceptance,
    // so the expected status words queue up in the order the block takes the words.
    // A row with a typed-in status word is checked against that instead.
    task automatic send_word(input logic o, input logic [1:0] t, input logic [3:0] p,
                             input logic [2:0] s, input bit fixed_on, input status_t fixed);
        status_t want;
        int      gap;
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            gap = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        op            <= o;
        target_dir    <= t;
        feedback_pins <= p;
        train_state   <= s;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        want = supervise_word(o, t, p, s);
        if (fixed_on)
        begin
            want = fixed;
        end
        pending_status_q.push_back(want);
    endtask

    // Register writes are only made with nothing in flight: the sender goes quiet, every
    // expected word is collected, and the pipeline is then given time to settle.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] val);
        in_valid <= 1'b0;
        while (pending_status_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY_SLACK) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_FB_INV:    fb_inv = val[3:0];
            REG_DRV_INV:   drv_inv = val[1:0];
            REG_PERIOD:    period_cfg = val;
            REG_ATT_LIMIT: limit_cfg = val;
            default:       ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [1:0] want,
                               input logic [1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Compares one accepted status word with the oldest expectation, field by field.
    task automatic check_status();
        status_t want;
        if (pending_status_q.size() == 0)
        begin
            $display("%0t: status word with nothing expected, got %h", $time,
                     {x_drive, y_drive, busy_res, done_res, fail_code, x_seen, y_seen,
                      current_dir, points_agree, set_correctly});
            mismatch_count++;
        end
        else
        begin
            want = pending_status_q.pop_front();
            check_field("x_drive", 2'(want.x_drive), 2'(x_drive));
            check_field("y_drive", 2'(want.y_drive), 2'(y_drive));
            check_field("busy_res", 2'(want.busy), 2'(busy_res));
            check_field("done_res", 2'(want.done), 2'(done_res));
            check_field("fail_code", want.fail, fail_code);
            check_field("x_seen", want.xs, x_seen);
            check_field("y_seen", want.ys, y_seen);
            check_field("current_dir", want.cur, current_dir);
            check_field("points_agree", 2'(want.agree), 2'(points_agree));
            check_field("set_correctly", 2'(want.ok), 2'(set_correctly));
        end
    endtask

    // Receiver: takes a word wherever out_valid is high and out_stall was low at the
    // edge, then picks the next stall level. A hold-off request is counted down here,
    // cycle by cycle, while the sender keeps offering words and the block fills up.
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                check_status();
            end
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= (recv_idle_pct > 0) && ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    // Main sequence: reset, directed table, then random phases under several settings.
    initial
    begin : stimulus
        logic       o;
        logic [1:0] t;
        logic [3:0] p;
        logic [2:0] s;
        int         waited;

        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        op = OP_TICK;
        target_dir = '0;
        feedback_pins = '0;
        train_state = '0;
        out_stall = 1'b0;
        mismatch_count = 0;
        hold_request = 0;
        send_idle_pct = 18;
        recv_idle_pct = 75;

        fb_inv = '0;
        drv_inv = '0;
        period_cfg = PERIOD_RESET;
        limit_cfg = LIMIT_RESET;
        sv_x_target = DIR_A;
        sv_y_target = DIR_A;
        sv_phase = PH_IDLE;
        sv_ticks = '0;
        sv_attempts = '0;
        sv_x_failed = 1'b0;
        sv_last_fail = '0;
        sv_drive = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Ticks while idle straight after reset: targets are both A, nothing is driven,
        // so only the decoded feedback and the fields built on it move.
        row_fixed(OP_TICK, 2'd0, 4'b0101, 3'd0,
                  '{1'b0, 1'b0, 1'b0, 1'b0, 2'd0, DIR_A, DIR_A, DIR_A, 1'b1, 1'b1});
        row_fixed(OP_TICK, 2'd3, 4'b1010, 3'd5,
                  '{1'b0, 1'b0, 1'b0, 1'b0, 2'd0, DIR_B, DIR_B, DIR_INVALID, 1'b0, 1'b0});
        row_fixed(OP_TICK, 2'd1, 4'b1111, 3'd7,
                  '{1'b0, 1'b0, 1'b0, 1'b0, 2'd0, DIR_INVALID, DIR_INVALID, DIR_INVALID,
                    1'b0, 1'b0});
        row_fixed(OP_TICK, 2'd2, 4'b0000, 3'd6,
                  '{1'b0, 1'b0, 1'b0, 1'b0, 2'd0, DIR_INVALID, DIR_INVALID, DIR_INVALID,
                    1'b0, 1'b0});
        row_fixed(OP_TICK, 2'd0, 4'b1001, 3'd2,
                  '{1'b0, 1'b0, 1'b0, 1'b0, 2'd0, DIR_A, DIR_B, DIR_INVALID, 1'b0, 1'b0});
        row_fixed(OP_TICK, 2'd0, 4'b0101, 3'd6,
                  '{1'b0, 1'b0, 1'b0, 1'b0, 2'd0, DIR_A, DIR_A, DIR_A, 1'b1, 1'b1});
        row_fixed(OP_TICK, 2'd0, 4'b0101, 3'd3,
                  '{1'b0, 1'b0, 1'b0, 1'b0, 2'd0, DIR_A, DIR_A, DIR_A, 1'b1, 1'b0});
        // A set command to B drives X at once; the set word itself is no tick.
        row_fixed(OP_SET, 2'd1, 4'b0101, 3'd4,
                  '{1'b1, 1'b0, 1'b1, 1'b0, 2'd0, DIR_A, DIR_A, DIR_INVALID, 1'b0, 1'b0});
        row_word(OP_TICK, 2'd0, 4'b0110, 3'd1);
        // A second set while the first is still waiting abandons the first.
        row_word(OP_SET, 2'd0, 4'b0110, 3'd1);
        // Zero period and zero limit behave as one; both drive pins and all feedback
        // pins inverted; a target of three is taken as invalid.
        row_cfg(REG_PERIOD, 16'd0);
        row_cfg(REG_ATT_LIMIT, 16'd0);
        row_cfg(REG_DRV_INV, 16'd3);
        row_cfg(REG_FB_INV, 16'd15);
        row_word(OP_SET, 2'd3, 4'b0110, 3'd6);
        row_word(OP_TICK, 2'd0, 4'b1111, 3'd6);
        row_word(OP_TICK, 2'd0, 4'b0000, 3'd7);
        // X never reports its target, so it gives up after one period; Y then succeeds.
        row_cfg(REG_FB_INV, 16'd0);
        row_cfg(REG_DRV_INV, 16'd1);
        row_word(OP_SET, 2'd1, 4'b0000, 3'd3);
        row_word(OP_TICK, 2'd1, 4'b0000, 3'd4);
        row_word(OP_TICK, 2'd1, 4'b1010, 3'd5);
        // Largest period and limit, then back to short ones mid-command.
        row_cfg(REG_PERIOD, 16'hFFFF);
        row_cfg(REG_ATT_LIMIT, 16'hFFFF);
        row_word(OP_SET, 2'd0, 4'b1010, 3'd0);
        row_word(OP_TICK, 2'd2, 4'b0101, 3'd1);
        row_word(OP_TICK, 2'd3, 4'b0101, 3'd2);
        row_cfg(REG_PERIOD, 16'd2);
        row_cfg(REG_ATT_LIMIT, 16'd2);
        row_word(OP_TICK, 2'd0, 4'b0101, 3'd0);
        row_word(OP_TICK, 2'd0, 4'b0101, 3'd6);
        row_word(OP_TICK, 2'd0, 4'b0101, 3'd6);

        foreach (plan_q[i])
        begin
            if (plan_q[i].kind == ROW_CFG)
            begin
                write_reg(plan_q[i].idx, plan_q[i].val);
            end
            else
            begin
                send_word(plan_q[i].o, plan_q[i].t, plan_q[i].p, plan_q[i].s,
                          plan_q[i].fixed_on, plan_q[i].fixed);
            end
        end

        // Random phases. The first pair idles mostly on the receiving side, the second
        // mostly on the sending side, the last pair not at all.
        for (int phase_no = 0; phase_no < 6; phase_no++)
        begin
            if (phase_no < 2)
            begin
                send_idle_pct = 18;
                recv_idle_pct = 75;
            end
            else if (phase_no < 4)
            begin
                send_idle_pct = 75;
                recv_idle_pct = 18;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(REG_FB_INV, (phase_no == 0) ? 16'd0 :
                                  (phase_no == 1) ? 16'd15 : 16'($urandom_range(0, 15)));
            write_reg(REG_DRV_INV, (phase_no == 0) ? 16'd0 :
                                   (phase_no == 1) ? 16'd3 : 16'($urandom_range(0, 3)));
            write_reg(REG_PERIOD, (phase_no == 2) ? 16'd0 : 16'($urandom_range(1, 4)));
            write_reg(REG_ATT_LIMIT, (phase_no == 3) ? 16'd0 :
                                     (phase_no == 5) ? 16'd1 : 16'($urandom_range(1, 4)));
            // A long hold-off at the receiver while words keep coming backs the block up.
            if (phase_no == 4)
            begin
                hold_request = HOLD_CYCLES;
            end
            repeat (PHASE_WORDS)
            begin
                // Mostly ticks with feedback that meets the targets, so commands run
                // to completion; some set commands, some noisy pins.
                o = ($urandom_range(0, 99) < 6) ? OP_SET : OP_TICK;
                t = 2'($urandom_range(0, 3));
                p = ($urandom_range(0, 99) < 65) ? matching_pins()
                                                 : 4'($urandom_range(0, 15));
                s = 3'($urandom_range(0, 7));
                send_word(o, t, p, s, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        waited = 0;
        while (pending_status_q.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (LATENCY_SLACK * 4) @(posedge clk);
        if (pending_status_q.size() != 0)
        begin
            $display("%0t: %0d status words never arrived", $time, pending_status_q.size());
            mismatch_count++;
        end

        if (mismatch_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin : watchdog
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/tps_pkg.sv
hw/rtl/tps_fb_decode.sv
hw/rtl/tps_sequencer.sv
hw/rtl/tps_status.sv
hw/rtl/turnout_pair_supervisor_core.sv
bench/tb.sv
